/* rtl/core/rmmst_pkg.sv */
`timescale 1ns / 1ps
// Package for the running min/max span tracker: sizes, cell data types,
// controller states and the signed distance function. No dependencies.
package rmmst_pkg;

   // Sizes
   localparam int MAX_ENTRIES = 256;
   localparam int VAL_W       = 32;
   localparam int REQ_W       = 9;
   localparam int CAP_W       = 9;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   // Width for count arithmetic: holds the register, the request and the count
   localparam int CALC_W      = (CNT_W > 10) ? CNT_W + 1 : 11;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

   // Probe travelling down the cell row
   typedef struct packed {
      logic             live;
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] shortest;
   } probe_type;

   // Which cells compare and which cells take a copy during one pass
   typedef struct packed {
      logic [CNT_W-1:0] held_start;
      logic [CNT_W-1:0] fill_end;
   } window_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // |a - b| of two signed values; always fits the unsigned width
   function automatic logic [VAL_W-1:0] span_of(logic [VAL_W-1:0] a,
                                                 logic [VAL_W-1:0] b);
      if ($signed(a) >= $signed(b)) begin
         return a - b;
      end else begin
         return b - a;
      end
   endfunction

endpackage

/* rtl/core/rmmst_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the span tracker: request and response.
// Depends on rmmst_pkg.
interface rmmst_req_if;
   import rmmst_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic [REQ_W-1:0]        repeat_count;

   modport source (output valid, output value, output repeat_count, input ready);
   modport sink   (input valid, input value, input repeat_count, output ready);
endinterface

interface rmmst_rsp_if;
   import rmmst_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] shortest_span;
   logic [VAL_W-1:0] longest_span;
   logic             spans_valid;
   logic             full_flag;
   logic [8:0]       entry_count;

   modport source (output valid, output shortest_span, output longest_span,
                   output spans_valid, output full_flag, output entry_count,
                   input ready);
   modport sink   (input valid, input shortest_span, input longest_span,
                   input spans_valid, input full_flag, input entry_count,
                   output ready);
endinterface

/* rtl/core/rmmst_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the span tracker row: holds one value, folds its
// distance into the passing probe, or takes a copy of the probe value.
// Depends on rmmst_pkg.
module rmmst_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rmmst_pkg::IDX_W-1:0] cell_index,
   input  rmmst_pkg::window_type       window,
   input  rmmst_pkg::probe_type        probe_prev,
   output rmmst_pkg::probe_type        probe_next
);
   import rmmst_pkg::*;

   logic [VAL_W-1:0] stored_ff;
   logic [VAL_W-1:0] stored_in;
   probe_type        probe_ff;
   probe_type        probe_in;
   logic [CNT_W-1:0] index_ext;
   logic             is_held;
   logic             is_fill;
   logic [VAL_W-1:0] gap_value;

   assign index_ext = CNT_W'(cell_index);
   assign is_held   = index_ext < window.held_start;
   assign is_fill   = !is_held && (index_ext < window.fill_end);
   assign gap_value = span_of(probe_prev.value, stored_ff);

   // Fold distance into the probe, or store a copy
   always_comb begin
      probe_in  = probe_prev;
      stored_in = stored_ff;
      if (probe_prev.live && is_held && (gap_value < probe_prev.shortest)) begin
         probe_in.shortest = gap_value;
      end
      if (probe_prev.live && is_fill) begin
         stored_in = probe_prev.value;
      end
   end

   // Stored value: payload, no reset
   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
   end

   // Probe register towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.live <= 1'b0;
      end else begin
         probe_ff.live <= probe_in.live;
      end
      probe_ff.value    <= probe_in.value;
      probe_ff.shortest <= probe_in.shortest;
   end

   assign probe_next = probe_ff;

endmodule

/* rtl/core/rmmst_chain.sv */
`timescale 1ns / 1ps
// Row of MAX_ENTRIES span tracker cells; the probe steps one cell a cycle.
// Depends on rmmst_pkg and rmmst_cell.
module rmmst_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  rmmst_pkg::window_type window,
   input  rmmst_pkg::probe_type  probe_head,
   output rmmst_pkg::probe_type  probe_tail
);
   import rmmst_pkg::*;

   probe_type links [MAX_ENTRIES+1];

   assign links[0] = probe_head;

   // Cell row
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      rmmst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .window     (window),
         .probe_prev (links[i]),
         .probe_next (links[i+1])
      );
   end

   assign probe_tail = links[MAX_ENTRIES];

endmodule

/* rtl/core/running_min_max_span_tracker.sv */
`timescale 1ns / 1ps
// Running min/max span tracker. Each request item adds repeat_count copies of
// a signed value (up to the capacity in csr_wr_data) and returns the least
// pairwise difference and max minus min of all held values. An item that adds
// values sends a probe down a row of 256 cells, one cell a cycle, before its
// response is registered; a query item (nothing added) skips the row. One
// item is in work at a time, but a new item is taken while the previous
// response still waits in the output register.
// Depends on rmmst_pkg, rmmst_if and rmmst_chain.
module running_min_max_span_tracker (
   input  logic                        clock,
   input  logic                        reset,
   rmmst_req_if.sink                   req_chan,
   rmmst_rsp_if.source                 rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [rmmst_pkg::CAP_W-1:0] csr_wr_data
);
   import rmmst_pkg::*;

   // Registers
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] held_ff;
   logic [VAL_W-1:0] least_ff;
   logic [VAL_W-1:0] greatest_ff;
   logic [VAL_W-1:0] shortest_ff;
   logic             two_plus_ff;
   logic             full_ff;
   window_type       window_ff;
   probe_type        launch_ff;
   state_type        state_ff;
   state_type        state_in;
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_short_ff;
   logic [VAL_W-1:0] rsp_long_ff;
   logic             rsp_spans_ff;
   logic             rsp_full_ff;
   logic [8:0]       rsp_count_ff;

   // Combinational
   logic              req_ready;
   logic              req_fire;
   logic              finish_go;
   logic [CALC_W-1:0] cap_eff;
   logic [CALC_W-1:0] held_c;
   logic [CALC_W-1:0] room;
   logic [CALC_W-1:0] req_c;
   logic [CALC_W-1:0] add_c;
   logic [CALC_W-1:0] new_held;
   logic              full_now;
   logic [CALC_W-1:0] count_ext;
   probe_type         chain_out;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // How many copies fit
   always_comb begin
      cap_eff = (CALC_W'(cap_ff) > CALC_W'(MAX_ENTRIES)) ?
                CALC_W'(MAX_ENTRIES) : CALC_W'(cap_ff);
      held_c  = CALC_W'(held_ff);
      room    = (held_c < cap_eff) ? cap_eff - held_c : '0;
      req_c   = CALC_W'(req_chan.repeat_count);
      add_c   = (req_c < room) ? req_c : room;
      full_now = add_c < req_c;
      new_held = held_c + add_c;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (add_c != '0) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (chain_out.live) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   ;
         ST_FINISH: finish_go = !rsp_valid_ff || rsp_chan.ready;
         default:   ;
      endcase
   end

   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Count, extremes and probe launch on acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= '0;
         least_ff       <= '0;
         greatest_ff    <= '0;
         launch_ff.live <= 1'b0;
      end else begin
         launch_ff.live <= req_fire && (add_c != '0);
         if (req_fire && (add_c != '0)) begin
            held_ff <= new_held[CNT_W-1:0];
            if (held_ff == '0) begin
               least_ff    <= req_chan.value;
               greatest_ff <= req_chan.value;
            end else begin
               if (req_chan.value < $signed(least_ff)) begin
                  least_ff <= req_chan.value;
               end
               if (req_chan.value > $signed(greatest_ff)) begin
                  greatest_ff <= req_chan.value;
               end
            end
         end
      end
      // Probe payload, no reset
      if (req_fire) begin
         launch_ff.value    <= req_chan.value;
         launch_ff.shortest <= shortest_ff;
      end
   end

   // Pass payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         window_ff.held_start <= held_ff;
         window_ff.fill_end   <= new_held[CNT_W-1:0];
         two_plus_ff          <= add_c >= CALC_W'(2);
         full_ff              <= full_now;
      end
   end

   // Cell row
   rmmst_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .window     (window_ff),
      .probe_head (launch_ff),
      .probe_tail (chain_out)
   );

   // Running shortest span, taken from the end of the row
   always_ff @(posedge clock) begin
      if (reset) begin
         shortest_ff <= '1;
      end else if ((state_ff == ST_SCAN) && chain_out.live) begin
         shortest_ff <= two_plus_ff ? '0 : chain_out.shortest;
      end
   end

   assign count_ext = CALC_W'(held_ff);

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_spans_ff <= held_ff >= CNT_W'(2);
         rsp_short_ff <= (held_ff >= CNT_W'(2)) ? shortest_ff : '0;
         rsp_long_ff  <= (held_ff >= CNT_W'(2)) ? greatest_ff - least_ff : '0;
         rsp_full_ff  <= full_ff;
         rsp_count_ff <= count_ext[8:0];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.shortest_span = rsp_short_ff;
   assign rsp_chan.longest_span  = rsp_long_ff;
   assign rsp_chan.spans_valid   = rsp_spans_ff;
   assign rsp_chan.full_flag     = rsp_full_ff;
   assign rsp_chan.entry_count   = rsp_count_ff;

endmodule

/* tb/tb_running_min_max_span_tracker.sv */
`timescale 1ns / 1ps
// Self-checking testbench for running_min_max_span_tracker: directed corner items, then
// random phases at several capacities, each result checked against a span predictor.
// Depends on rmmst_pkg, rmmst_if and the tracker RTL.
module tb_running_min_max_span_tracker;
   import rmmst_pkg::*;

   localparam int CLK_HALF     = 2;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SETTLE_CYCLES = 300;

   // One response item as seen on the result channel
   typedef struct {
      logic [VAL_W-1:0] shortest;
      logic [VAL_W-1:0] longest;
      logic             valid;
      logic             full;
      logic [8:0]       count;
   } span_result_type;

   // Span predictor plus the queue of results still owed by the block
   class span_book;
      logic [VAL_W-1:0] held_values[$];
      logic [VAL_W-1:0] least;
      logic [VAL_W-1:0] greatest;
      logic [VAL_W-1:0] shortest;
      logic [CAP_W-1:0] capacity;
      span_result_type  expected_spans[$];
      int               mismatches;

      function new();
         least      = '0;
         greatest   = '0;
         shortest   = '1;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] c);
         capacity = c;
      endfunction

      function int outstanding();
         return expected_spans.size();
      endfunction

      // Free slots under the effective capacity (saturated at MAX_ENTRIES)
      function int unsigned room();
         int unsigned cap_eff;
         cap_eff = (32'(capacity) > MAX_ENTRIES) ? MAX_ENTRIES : 32'(capacity);
         return (held_values.size() < cap_eff) ? cap_eff - held_values.size() : 0;
      endfunction

      function logic [VAL_W-1:0] any_held();
         if (held_values.size() == 0) return $urandom;
         return held_values[$urandom_range(0, held_values.size() - 1)];
      endfunction

      // Absolute difference via a 64-bit signed subtraction
      function logic [VAL_W-1:0] abs_gap(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
         longint diff;
         diff = longint'($signed(a)) - longint'($signed(b));
         if (diff < 0) diff = -diff;
         return diff[VAL_W-1:0];
      endfunction

      // Accepted request item: update the set and queue the result it owes
      function void note_item(logic [VAL_W-1:0] v, logic [REQ_W-1:0] n);
         int unsigned     free_slots;
         int unsigned     copies;
         span_result_type r;
         free_slots = room();
         copies     = (32'(n) < free_slots) ? 32'(n) : free_slots;
         if (copies > 0) begin
            foreach (held_values[i]) begin
               if (abs_gap(v, held_values[i]) < shortest) shortest = abs_gap(v, held_values[i]);
            end
            if (copies >= 2) shortest = '0;
            if (held_values.size() == 0) begin
               least    = v;
               greatest = v;
            end else begin
               if ($signed(v) < $signed(least)) least = v;
               if ($signed(v) > $signed(greatest)) greatest = v;
            end
            repeat (copies) held_values = {held_values, v};
         end
         r.full  = (copies < 32'(n));
         r.count = 9'(held_values.size());
         r.valid = (held_values.size() >= 2);
         if (r.valid) begin
            r.shortest = shortest;
            r.longest  = greatest - least;
         end else begin
            r.shortest = '0;
            r.longest  = '0;
         end
         expected_spans = {expected_spans, r};
      endfunction

      function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Response item: compare field by field with the oldest expectation
      function void check_result(span_result_type got);
         span_result_type want;
         if (expected_spans.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none, actual count %0d shortest %0h",
                     $time, got.count, got.shortest);
            return;
         end
         want = expected_spans.pop_front();
         compare_field("shortest_span", want.shortest, got.shortest);
         compare_field("longest_span", want.longest, got.longest);
         compare_field("spans_valid", VAL_W'(want.valid), VAL_W'(got.valid));
         compare_field("full_flag", VAL_W'(want.full), VAL_W'(got.full));
         compare_field("entry_count", VAL_W'(want.count), VAL_W'(got.count));
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;
   bit               no_gaps;
   int               cycle_count;
   span_book         book;

   rmmst_req_if req_chan();
   rmmst_rsp_if rsp_chan();

   running_min_max_span_tracker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // Gap lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Handshake monitor and run watchdog
   always @(posedge clock) begin
      span_result_type seen;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            book.note_item(req_chan.value, req_chan.repeat_count);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.shortest = rsp_chan.shortest_span;
            seen.longest  = rsp_chan.longest_span;
            seen.valid    = rsp_chan.spans_valid;
            seen.full     = rsp_chan.full_flag;
            seen.count    = rsp_chan.entry_count;
            book.check_result(seen);
         end
      end
   end

   // Result side: random stalls between bursts of ready, some of them long
   initial begin
      int stall;
      int burst;
      rsp_chan.ready = 1'b0;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         burst = ($urandom_range(0, 19) == 0) ? 400 : $urandom_range(1, 30);
         repeat (burst) @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic [VAL_W-1:0] v, input logic [REQ_W-1:0] n);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.value        <= v;
      req_chan.repeat_count <= n;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   // Hold the request side until every owed result has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (book.outstanding() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] c);
      drain_results();
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      book.set_capacity(c);
   endtask

   // Random items; duplicates only where allowed, since they pin the shortest span at zero
   task automatic run_phase(input int items, input bit allow_dup);
      logic [VAL_W-1:0] v;
      logic [REQ_W-1:0] n;
      int               r;
      repeat (items) begin
         r = $urandom_range(0, 99);
         if (r < 60 || book.held_values.size() == 0) begin
            v = $urandom;
         end else if (r < 85) begin
            v = book.any_held() + ($urandom_range(0, 1) ? 32'($urandom_range(1, 1000))
                                                        : -32'($urandom_range(1, 1000)));
         end else if (allow_dup && r < 93) begin
            case ($urandom_range(0, 4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0001;
            endcase
         end else if (allow_dup) begin
            v = book.any_held();
         end else begin
            v = $urandom;
         end

         r = $urandom_range(0, 99);
         if (r < 20) n = '0;
         else if (r < 75) n = 9'd1;
         else if (!allow_dup) n = (book.room() <= 1) ? 9'($urandom_range(2, 256)) : 9'd1;
         else if (r < 90) n = 9'($urandom_range(2, 8));
         else if (r < 96) n = 9'($urandom_range(9, 255));
         else n = 9'd256;

         if ($urandom_range(0, 199) == 0) drain_results();
         send_item(v, n);
      end
   endtask

   initial begin
      book                  = new();
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      no_gaps               = 1'b0;
      cycle_count           = 0;
      req_chan.valid        = 1'b0;
      req_chan.value        = '0;
      req_chan.repeat_count = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero capacity: every add refused; query on an empty set
      write_capacity(9'd0);
      send_item(32'h0000_0005, 9'd3);
      send_item(32'hFFFF_FFFF, 9'd0);
      // Capacity one: partial fit, then set full, then a query with fewer than two held
      write_capacity(9'd1);
      send_item(32'h8000_0000, 9'd3);
      send_item(32'h0000_0007, 9'd1);
      send_item(32'h7FFF_FFFF, 9'd0);
      // Full capacity: extremes give the widest spans, then single adds narrow them
      write_capacity(9'd256);
      send_item(32'h7FFF_FFFF, 9'd1);
      send_item(32'h0000_0000, 9'd1);
      send_item(32'hFFFF_FFFF, 9'd1);
      send_item(32'h0000_0001, 9'd1);
      send_item(32'h4000_0000, 9'd1);
      send_item(32'hC000_0000, 9'd0);
      // Capacity lowered below the count: adds refused, nothing removed
      write_capacity(9'd3);
      send_item(32'h0000_0002, 9'd1);
      send_item(32'h0000_0002, 9'd256);
      send_item(32'h0000_0002, 9'd0);

      // Random phases, one of them without sender gaps
      write_capacity(9'd40);
      no_gaps = 1'b1;
      run_phase(150, 1'b0);
      no_gaps = 1'b0;
      write_capacity(9'd10);
      run_phase(40, 1'b0);
      write_capacity(9'd120);
      run_phase(200, 1'b0);
      write_capacity(9'd200);
      run_phase(200, 1'b1);
      write_capacity(9'd255);
      run_phase(200, 1'b1);
      write_capacity(9'd256);
      run_phase(200, 1'b1);
      write_capacity(9'd0);
      run_phase(60, 1'b1);
      write_capacity(9'd256);
      run_phase(150, 1'b1);

      // Wind down and let any stray result show up
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/rmmst_pkg.sv
rtl/core/rmmst_if.sv
rtl/core/rmmst_cell.sv
rtl/core/rmmst_chain.sv
rtl/core/running_min_max_span_tracker.sv
tb/tb_running_min_max_span_tracker.sv
